// File: rtl/core/trqs_pkg.sv
// ----------------------------------------------------------------------------
// trqs_pkg
// Shared types and codes for the tagged ring queue with search.
// ----------------------------------------------------------------------------
package trqs_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int TAG_W     = 32;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_PUSH_FULL = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FRONT_RD,
    S_FRONT_WB,
    S_SCAN,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic exec;
    logic front_rd;
    logic front_wb;
    logic scan;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             need_front;
    logic             scan_done;
  } sts_t;

endpackage

// File: rtl/core/trqs_ctrl.sv
// ----------------------------------------------------------------------------
// trqs_ctrl
// Request sequencer: steps one request through execute, front refresh or
// key scan, then hands the result to the output register.
// ----------------------------------------------------------------------------
module trqs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output trqs_pkg::cmd_t cmd,
  input  trqs_pkg::sts_t sts
);
  import trqs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.req == REQ_LOOKUP) state_nxt = S_SCAN;
        else if (sts.need_front)  state_nxt = S_FRONT_RD;
        else                      state_nxt = S_DONE;
      end
      S_FRONT_RD: state_nxt = S_FRONT_WB;
      S_FRONT_WB: state_nxt = S_DONE;
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      S_EXEC:     cmd.exec     = 1'b1;
      S_FRONT_RD: cmd.front_rd = 1'b1;
      S_FRONT_WB: cmd.front_wb = 1'b1;
      S_SCAN:     cmd.scan     = 1'b1;
      S_DONE:     cmd.load_out = out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out)             out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted request did not enter execute");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.load_out)
    else $error("result register overwritten while stalled");

  a_scan_only_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (sts.req == REQ_LOOKUP))
    else $error("scan running for a non-lookup request");

endmodule

// File: rtl/core/trqs_dp.sv
// ----------------------------------------------------------------------------
// trqs_dp
// Queue datapath: data/tag memories, head and count, front/back shadows,
// key compare for the scan and the result register.
// ----------------------------------------------------------------------------
module trqs_dp #(
  parameter int DEPTH = trqs_pkg::DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  trqs_pkg::cmd_t              cmd,
  output trqs_pkg::sts_t              sts,
  input  logic [trqs_pkg::REQ_W-1:0]  in_req_type,
  input  logic [trqs_pkg::DATA_W-1:0] in_data_value,
  input  logic [trqs_pkg::TAG_W-1:0]  in_tag_value,
  output logic [trqs_pkg::STAT_W-1:0] out_status,
  output logic                        out_found,
  output logic [trqs_pkg::TAG_W-1:0]  out_found_tag,
  output logic [trqs_pkg::DATA_W-1:0] out_front_data,
  output logic [trqs_pkg::DATA_W-1:0] out_back_data,
  output logic [CW-1:0]               out_occupancy
);
  import trqs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [DATA_W-1:0] data_mem [DEPTH];
  logic [TAG_W-1:0]  tag_mem  [DEPTH];

  logic [REQ_W-1:0]  req_r;
  logic [DATA_W-1:0] key_r;
  logic [TAG_W-1:0]  tagin_r;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [DATA_W-1:0] rd_data_r;
  logic [TAG_W-1:0]  rd_tag_r;
  logic [DATA_W-1:0] front_r, back_r;
  logic [STAT_W-1:0] status_r;
  logic              found_r;
  logic [TAG_W-1:0]  ftag_r;

  logic              mem_we;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic              issue, hit;

  // head + offset, wrapped into the ring; head is below DEPTH, the offset at most DEPTH
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, off};
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign wr_addr = slot_of(head_r, count_r[AW-1:0]);
  assign mem_we  = cmd.exec && (req_r == REQ_PUSH) && (count_r != FULL_CNT);
  assign issue   = cmd.scan && (idx_r < count_r);
  assign rd_addr = cmd.front_rd ? head_r : slot_of(head_r, idx_r[AW-1:0]);
  assign hit     = rd_vld_r && (rd_data_r == key_r);

  assign sts.req        = req_r;
  assign sts.need_front = (req_r == REQ_POP) && (count_r > CW'(1));
  assign sts.scan_done  = hit || (!rd_vld_r && (idx_r == count_r));

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    rd_vld_nxt = rd_vld_r;
    if (cmd.exec) begin
      case (req_r)
        REQ_PUSH: begin
          if (count_r != FULL_CNT) count_nxt = count_r + CW'(1);
        end
        REQ_POP: begin
          if (count_r != '0) begin
            head_nxt  = slot_of(head_r, AW'(1));
            count_nxt = count_r - CW'(1);
          end
        end
        REQ_CLEAR: begin
          head_nxt  = '0;
          count_nxt = '0;
        end
        REQ_LOOKUP: begin
          idx_nxt    = '0;
          rd_vld_nxt = 1'b0;
        end
        default: begin
          head_nxt = head_r;
        end
      endcase
    end
    if (cmd.scan) begin
      rd_vld_nxt = issue;
      if (issue) idx_nxt = idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      count_r  <= '0;
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  // storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      data_mem[wr_addr] <= key_r;
      tag_mem[wr_addr]  <= tagin_r;
    end
    rd_data_r <= data_mem[rd_addr];
    rd_tag_r  <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r   <= in_req_type;
      key_r   <= in_data_value;
      tagin_r <= in_tag_value;
    end
    if (cmd.exec) begin
      found_r <= 1'b0;
      ftag_r  <= '0;
      case (req_r)
        REQ_PUSH: begin
          if (count_r == FULL_CNT) begin
            status_r <= ST_PUSH_FULL;
          end else begin
            status_r <= ST_OK;
            back_r   <= key_r;
            if (count_r == '0) front_r <= key_r;
          end
        end
        REQ_POP:    status_r <= (count_r == '0) ? ST_POP_EMPTY : ST_OK;
        REQ_LOOKUP: status_r <= ST_NOT_FOUND;
        default:    status_r <= ST_OK;
      endcase
    end
    if (cmd.front_wb) front_r <= rd_data_r;
    if (cmd.scan && hit) begin
      status_r <= ST_OK;
      found_r  <= 1'b1;
      ftag_r   <= rd_tag_r;
    end
    if (cmd.load_out) begin
      out_status     <= status_r;
      out_found      <= found_r;
      out_found_tag  <= ftag_r;
      out_front_data <= (count_r == '0) ? '0 : front_r;
      out_back_data  <= (count_r == '0) ? '0 : back_r;
      out_occupancy  <= count_r;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("occupancy above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, head_r} < (AW+1)'(DEPTH))
    else $error("head slot outside ring");

  a_scan_steady: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (idx_r <= count_r))
    else $error("scan index ran past occupancy");

endmodule

// File: rtl/core/tagged_ring_queue_with_search.sv
// ----------------------------------------------------------------------------
// tagged_ring_queue_with_search
// Circular queue of data/tag pairs with push, pop, clear and key lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats arrive on in_* (valid/ready): a request code, a data value
//   (push data or lookup key) and a tag. Each request yields one result beat
//   on out_*: status, found flag and tag, front and back data, occupancy.
//   One request is in flight at a time; in_ready is high while the
//   sequencer is idle, even if the previous result still waits on out_*.
//   An accepted request first executes. Push, clear and a pop that empties
//   or fails then go to the result; a pop that leaves entries first refreshes
//   the front with one memory read, and a lookup first scans the data memory
//   read port one entry per cycle, up to the occupancy, ending at a hit. The
//   result loads into out_* when it is free, and the next request is taken
//   in the cycle after a result loads.
//   A stalled result holds on out_* until out_ready; the next result then
//   waits in the sequencer. Reset empties the queue (head and count to
//   zero); the memories keep their contents, which are never read unwritten.
// ----------------------------------------------------------------------------
module tagged_ring_queue_with_search #(
  parameter int DEPTH = trqs_pkg::DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [trqs_pkg::REQ_W-1:0]  in_req_type,
  input  logic [trqs_pkg::DATA_W-1:0] in_data_value,
  input  logic [trqs_pkg::TAG_W-1:0]  in_tag_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [trqs_pkg::STAT_W-1:0] out_status,
  output logic                        out_found,
  output logic [trqs_pkg::TAG_W-1:0]  out_found_tag,
  output logic [trqs_pkg::DATA_W-1:0] out_front_data,
  output logic [trqs_pkg::DATA_W-1:0] out_back_data,
  output logic [CW-1:0]               out_occupancy
);
  import trqs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  trqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  trqs_dp #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (in_req_type),
    .in_data_value  (in_data_value),
    .in_tag_value   (in_tag_value),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_found_tag  (out_found_tag),
    .out_front_data (out_front_data),
    .out_back_data  (out_back_data),
    .out_occupancy  (out_occupancy)
  );

endmodule
